// ----- rtl/bcc_pkg.sv -----
// Shared types and constants of the button click classifier.
package bcc_pkg;

	localparam int unsigned CfgWidth    = 16;
	localparam int unsigned CfgIdxWidth = 8;

	typedef logic [CfgIdxWidth-1:0] cfg_idx_t;
	typedef logic [CfgWidth-1:0]    cfg_val_t;

	// Register indexes on the configuration port
	localparam cfg_idx_t REG_DEBOUNCE = 8'd0;
	localparam cfg_idx_t REG_DC_WIN   = 8'd1;
	localparam cfg_idx_t REG_SETTLE   = 8'd2;
	localparam cfg_idx_t REG_HOLD     = 8'd3;

	// Register reset values
	localparam cfg_val_t DEBOUNCE_RST = 16'd5;
	localparam cfg_val_t DC_WIN_RST   = 16'd250;
	localparam cfg_val_t SETTLE_RST   = 16'd300;
	localparam cfg_val_t HOLD_RST     = 16'd500;

	typedef struct packed {
		cfg_val_t debounce;
		cfg_val_t dc_window;
		cfg_val_t settle;
		cfg_val_t hold;
	} cfg_t;

	typedef struct packed {
		logic single_click;
		logic double_click;
		logic hold_event;
	} flags_t;

endpackage

// ----- rtl/bcc_debounce.sv -----
// Debounce filter: settle stamp, previous raw level and stable level.
module bcc_debounce #(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  raw_level,
	input  logic [TIME_WIDTH-1:0] now,
	input  bcc_pkg::cfg_val_t     debounce,
	output logic                  pressed
);

	logic [TIME_WIDTH-1:0] settle_q;
	logic [TIME_WIDTH-1:0] settle_n;
	logic [TIME_WIDTH-1:0] age;
	logic                  stable_q;
	logic                  stable_n;
	logic                  prev_q;

	always_comb begin
		settle_n = (raw_level != prev_q) ? now : settle_q;
		age      = now - settle_n;
		stable_n = (age > TIME_WIDTH'(debounce)) ? raw_level : stable_q;
	end

	assign pressed = ~stable_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= '0;
			stable_q <= 1'b1;
			prev_q   <= 1'b1;
		end else if (step) begin
			settle_q <= settle_n;
			stable_q <= stable_n;
			prev_q   <= raw_level;
		end
	end

endmodule

// ----- rtl/bcc_classify.sv -----
// Press tracking and click / hold classification from the debounced level.
module bcc_classify #(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  pressed,
	input  logic [TIME_WIDTH-1:0] now,
	input  bcc_pkg::cfg_t         cfg,
	output bcc_pkg::flags_t       flags
);

	logic                  active_q, pending_q, armed_q, dbl_rep_q, hold_rep_q;
	logic [TIME_WIDTH-1:0] press_q, release_q;

	logic                  active_n, pending_n, armed_n, dbl_rep_n, hold_rep_n;
	logic [TIME_WIDTH-1:0] press_n, release_n;
	logic [TIME_WIDTH-1:0] gap, since_rel, since_press;
	logic                  in_window, settled, holding;

	always_comb begin
		active_n   = active_q;
		pending_n  = pending_q;
		armed_n    = armed_q;
		dbl_rep_n  = dbl_rep_q;
		hold_rep_n = hold_rep_q;
		press_n    = press_q;
		release_n  = release_q;
		flags      = '0;

		// press and release edges
		if (pressed && !active_q) begin
			active_n  = 1'b1;
			press_n   = now;
			dbl_rep_n = 1'b0;
		end
		if (!pressed && active_q) begin
			active_n  = 1'b0;
			pending_n = 1'b1;
			release_n = now;
		end

		gap         = press_n - release_n;
		since_rel   = now - release_n;
		since_press = now - press_n;
		in_window   = gap <= TIME_WIDTH'(cfg.dc_window);
		settled     = pending_n && (since_rel > TIME_WIDTH'(cfg.settle));
		holding     = since_press >= TIME_WIDTH'(cfg.hold);

		if (active_n && in_window && !dbl_rep_n)
			armed_n = 1'b1;

		if (settled) begin
			if (!hold_rep_n && !dbl_rep_n) begin
				if (armed_n) begin
					flags.double_click = 1'b1;
					dbl_rep_n          = 1'b1;
				end else begin
					flags.single_click = 1'b1;
				end
			end else if (dbl_rep_n) begin
				dbl_rep_n = 1'b0;
			end
			armed_n    = 1'b0;
			pending_n  = 1'b0;
			hold_rep_n = 1'b0;
		end

		if (holding && active_n && !hold_rep_n) begin
			hold_rep_n       = 1'b1;
			flags.hold_event = ~dbl_rep_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			pending_q  <= 1'b0;
			armed_q    <= 1'b0;
			dbl_rep_q  <= 1'b0;
			hold_rep_q <= 1'b0;
			press_q    <= '0;
			release_q  <= '0;
		end else if (step) begin
			active_q   <= active_n;
			pending_q  <= pending_n;
			armed_q    <= armed_n;
			dbl_rep_q  <= dbl_rep_n;
			hold_rep_q <= hold_rep_n;
			press_q    <= press_n;
			release_q  <= release_n;
		end
	end

endmodule

// ----- rtl/button_click_classifier_unit.sv -----
// Top level of the button click classifier: ports, config registers, pipeline.
//
// Usage:
//   Input channel (in_valid / in_stall): one transaction per poll, carrying the
//   raw active-low pin sample button_level and the millisecond stamp now_ms.
//   Output channel (out_valid / out_stall): exactly one transaction per poll,
//   carrying the single_click, double_click and hold_event flags.
//   Config channel (cfg_valid / cfg_ready): writes register cfg_index with the
//   low 16 bits of cfg_data; unknown indexes are dropped. cfg_ready is always
//   high. Write only while no poll is in flight.
// Timing:
//   A poll lands in the input register, passes the debounce and classify
//   logic combinationally, and its result lands in the output register,
//   from which it is offered. One poll per cycle is sustained while the
//   output is not stalled; the state update is a compare-and-update.
// Stall and reset:
//   A stalled output holds the result register and the input register, and
//   in_stall rises until the output transaction completes.
//   Reset clears both pipeline valids, loads the register defaults (5, 250,
//   300, 500 ms) and puts the button state in its released condition.
module button_click_classifier_unit #(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// poll input
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       button_level,
	input  logic [31:0]                now_ms,
	// classification result
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       single_click,
	output logic                       double_click,
	output logic                       hold_event,
	// configuration writes
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  bcc_pkg::cfg_idx_t          cfg_index,
	input  bcc_pkg::cfg_val_t          cfg_data
);

	bcc_pkg::cfg_t         cfg_q;
	logic                  valid_s1;
	logic                  level_s1;
	logic [TIME_WIDTH-1:0] now_s1;
	logic                  valid_s2;
	bcc_pkg::flags_t       flags_s2;
	bcc_pkg::flags_t       flags;
	logic                  advance;
	logic                  step;
	logic                  pressed;

	// The whole pipe moves together unless the result is stuck downstream
	assign advance   = ~(valid_s2 & out_stall);
	assign step      = advance & valid_s1;
	assign in_stall  = ~advance;
	assign cfg_ready = 1'b1;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce  <= bcc_pkg::DEBOUNCE_RST;
			cfg_q.dc_window <= bcc_pkg::DC_WIN_RST;
			cfg_q.settle    <= bcc_pkg::SETTLE_RST;
			cfg_q.hold      <= bcc_pkg::HOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bcc_pkg::REG_DEBOUNCE: cfg_q.debounce  <= cfg_data;
				bcc_pkg::REG_DC_WIN:   cfg_q.dc_window <= cfg_data;
				bcc_pkg::REG_SETTLE:   cfg_q.settle    <= cfg_data;
				bcc_pkg::REG_HOLD:     cfg_q.hold      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register: capture a poll whenever the pipe advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			level_s1 <= button_level;
			now_s1   <= TIME_WIDTH'(now_ms);
		end
	end

	// Debounce the raw level; state moves only when a poll is consumed
	bcc_debounce #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_debounce (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.raw_level (level_s1),
		.now       (now_s1),
		.debounce  (cfg_q.debounce),
		.pressed   (pressed)
	);

	// Track presses and releases and classify
	bcc_classify #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_classify (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.pressed (pressed),
		.now     (now_s1),
		.cfg     (cfg_q),
		.flags   (flags)
	);

	// Result register: hold while stalled, advance otherwise
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			flags_s2 <= flags;
		end
	end

	assign out_valid    = valid_s2;
	assign single_click = flags_s2.single_click;
	assign double_click = flags_s2.double_click;
	assign hold_event   = flags_s2.hold_event;

endmodule

// ----- dv/tb_button_click_classifier_unit.sv -----
// Self-checking testbench of the button click classifier: directed and random polls.
module tb_button_click_classifier_unit;
	timeunit 1ns;
	timeprecision 1ps;

	// Index that no register answers to; writes to it must be dropped.
	localparam bcc_pkg::cfg_idx_t REG_NONE = 8'd4;

	// One poll as the sender offers it.
	typedef struct {
		logic        level;
		logic [31:0] stamp;
	} poll_t;

	// Clock, reset and block ports. Every input starts at a known value.
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        button_level = 1'b1;
	logic [31:0] now_ms = '0;

	logic out_valid;
	logic out_stall = 1'b0;
	logic single_click;
	logic double_click;
	logic hold_event;

	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	bcc_pkg::cfg_idx_t cfg_index = bcc_pkg::REG_DEBOUNCE;
	bcc_pkg::cfg_val_t cfg_data = '0;

	button_click_classifier_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.button_level(button_level),
		.now_ms      (now_ms),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.single_click(single_click),
		.double_click(double_click),
		.hold_event  (hold_event),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Polls waiting to be offered, and the flags each accepted poll must produce.
	poll_t           poll_q[$];
	bcc_pkg::flags_t pending_flags[$];

	int n_queued   = 0;
	int n_accepted = 0;
	int n_checked  = 0;
	int n_errors   = 0;

	// Random idling on both channels; cleared for the final phase.
	logic idle_en  = 1'b1;
	// Long receiver hold-off that backs the pipeline up into in_stall.
	logic hold_off = 1'b0;

	// Mirror of the configuration registers, reset defaults from the package.
	bcc_pkg::cfg_val_t mir_debounce = bcc_pkg::DEBOUNCE_RST;
	bcc_pkg::cfg_val_t mir_window   = bcc_pkg::DC_WIN_RST;
	bcc_pkg::cfg_val_t mir_settle   = bcc_pkg::SETTLE_RST;
	bcc_pkg::cfg_val_t mir_hold     = bcc_pkg::HOLD_RST;

	// Classifier state as the block should hold it after each accepted poll.
	logic [31:0] deb_stamp  = '0;
	logic        lvl_stable = 1'b1;
	logic        lvl_last   = 1'b1;
	logic        btn_down   = 1'b0;
	logic        rel_wait   = 1'b0;
	logic [31:0] down_stamp = '0;
	logic [31:0] up_stamp   = '0;
	logic        dbl_armed  = 1'b0;
	logic        dbl_sent   = 1'b0;
	logic        hold_sent  = 1'b0;

	// Stamp that the stimulus generator advances from poll to poll.
	logic [31:0] clock_ms = '0;

	// Advance the classifier by one poll and return the flags it raises.
	// All stamp differences wrap at 32 bits, so a wrapped or backward stamp
	// simply yields a large difference.
	function automatic bcc_pkg::flags_t classify_poll(logic lvl, logic [31:0] stamp);
		bcc_pkg::flags_t f;
		logic [31:0]     since_edge;
		logic [31:0]     gap_up_down;
		logic [31:0]     since_up;
		logic [31:0]     since_down;
		logic            in_window;
		logic            settled;
		logic            holding;

		f = '0;

		// Debounce: restart the settle stamp on any raw change, accept the
		// raw level once it has been steady longer than the debounce time.
		if (lvl != lvl_last)
			deb_stamp = stamp;
		since_edge = stamp - deb_stamp;
		if (since_edge > {16'h0, mir_debounce})
			lvl_stable = lvl;
		lvl_last = lvl;

		// Press and release edges of the debounced level.
		if (!lvl_stable && !btn_down) begin
			btn_down   = 1'b1;
			down_stamp = stamp;
			dbl_sent   = 1'b0;
		end
		if (lvl_stable && btn_down) begin
			btn_down   = 1'b0;
			rel_wait   = 1'b1;
			up_stamp   = stamp;
		end

		// The window test runs on every poll, even before the first release.
		gap_up_down = down_stamp - up_stamp;
		since_up    = stamp - up_stamp;
		since_down  = stamp - down_stamp;
		in_window   = gap_up_down <= {16'h0, mir_window};
		settled     = rel_wait && (since_up > {16'h0, mir_settle});
		holding     = since_down >= {16'h0, mir_hold};

		if (btn_down && in_window && !dbl_armed && !dbl_sent)
			dbl_armed = 1'b1;

		if (settled) begin
			if (!hold_sent && !dbl_sent) begin
				if (dbl_armed) begin
					f.double_click = 1'b1;
					dbl_sent       = 1'b1;
				end else begin
					f.single_click = 1'b1;
				end
			end else if (dbl_sent) begin
				dbl_sent = 1'b0;
			end
			dbl_armed = 1'b0;
			rel_wait  = 1'b0;
			hold_sent = 1'b0;
		end

		// A hold right after a double click is swallowed but still latched.
		if (holding && btn_down && !hold_sent) begin
			hold_sent = 1'b1;
			if (!dbl_sent)
				f.hold_event = 1'b1;
		end

		return f;
	endfunction

	// Sender: offer queued polls, hold a stalled one, predict on acceptance.
	int src_gap = 0;

	always @(posedge clk) begin
		poll_t nxt;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				pending_flags.push_back(classify_poll(button_level, now_ms));
				n_accepted++;
			end
			// Move on only when nothing is offered or the offer just went through.
			if (!in_valid || !in_stall) begin
				if (src_gap > 0) begin
					src_gap--;
					in_valid <= 1'b0;
				end else if (idle_en && poll_q.size() != 0 && $urandom_range(0, 9) == 0) begin
					// Start an idle burst that includes this cycle.
					src_gap = $urandom_range(0, 15);
					in_valid <= 1'b0;
				end else if (poll_q.size() != 0) begin
					nxt = poll_q.pop_front();
					in_valid     <= 1'b1;
					button_level <= nxt.level;
					now_ms       <= nxt.stamp;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: compare each result with the oldest prediction, then pick the
	// stall for the next cycle from the burst counter and the long hold-off.
	int sink_gap = 0;

	always @(posedge clk) begin
		bcc_pkg::flags_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				n_checked++;
				if (pending_flags.size() == 0) begin
					$error("result transaction with no poll outstanding");
					n_errors++;
				end else begin
					want = pending_flags.pop_front();
					if (single_click !== want.single_click) begin
						$error("single_click: expected %0b, actual %0b",
							want.single_click, single_click);
						n_errors++;
					end
					if (double_click !== want.double_click) begin
						$error("double_click: expected %0b, actual %0b",
							want.double_click, double_click);
						n_errors++;
					end
					if (hold_event !== want.hold_event) begin
						$error("hold_event: expected %0b, actual %0b",
							want.hold_event, hold_event);
						n_errors++;
					end
				end
			end
			if (sink_gap > 0)
				sink_gap--;
			else if (idle_en && $urandom_range(0, 9) == 0)
				sink_gap = $urandom_range(1, 16);
			out_stall <= hold_off || (sink_gap > 0);
		end
	end

	// Pressure: once traffic is flowing, stall the output for a long stretch
	// while the sender keeps offering, so in_stall has to rise.
	initial begin
		while (n_accepted < 200)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (200) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	task automatic add_poll(logic lvl, logic [31:0] stamp);
		poll_t p;
		p.level = lvl;
		p.stamp = stamp;
		poll_q.push_back(p);
		n_queued++;
		clock_ms = stamp;
	endtask

	task automatic poll_after(logic lvl, int adv);
		add_poll(lvl, clock_ms + adv);
	endtask

	// Hold one level for exactly span_ms, split over a few polls of random spacing.
	task automatic hold_level(logic lvl, int span_ms);
		int n;
		int rem;
		int a;
		n   = $urandom_range(2, 8);
		rem = span_ms;
		for (int i = 0; i < n; i++) begin
			if (i == n - 1)
				a = rem;
			else
				a = $urandom_range(0, 2 * rem / (n - i));
			if (a > rem)
				a = rem;
			poll_after(lvl, a);
			rem -= a;
		end
	endtask

	// Contact chatter: a few quick toggles, ending on the given level.
	task automatic chatter(logic lvl);
		int k;
		k = $urandom_range(0, 3);
		for (int i = 0; i < k; i++) begin
			poll_after(!lvl, $urandom_range(0, int'(mir_debounce)));
			poll_after(lvl, $urandom_range(0, int'(mir_debounce)));
		end
	endtask

	// Pick a duration around a threshold: up to it, right at the edge, or past it.
	function automatic int around(int th);
		int d;
		case ($urandom_range(0, 2))
			0: d = $urandom_range(0, th);
			1: d = th + $urandom_range(0, 4) - 2;
			default: d = th + $urandom_range(0, th + 20);
		endcase
		return (d < 0) ? 0 : d;
	endfunction

	// One to three presses with chatter, presses near the hold time and gaps
	// near the double click window, then a release long enough to settle or not.
	task automatic gesture();
		int presses;
		presses = $urandom_range(1, 3);
		for (int p = 0; p < presses; p++) begin
			chatter(1'b0);
			hold_level(1'b0, around(int'(mir_hold)) + int'(mir_debounce) + 1);
			chatter(1'b1);
			if (p == presses - 1)
				hold_level(1'b1, around(int'(mir_settle)) + int'(mir_debounce) + 1);
			else
				hold_level(1'b1, around(int'(mir_window)) + int'(mir_debounce) + 1);
		end
	endtask

	// Unstructured polls: random levels, random jumps, backward steps.
	task automatic noise();
		int k;
		k = $urandom_range(1, 8);
		for (int i = 0; i < k; i++) begin
			case ($urandom_range(0, 3))
				0: add_poll(1'($urandom_range(0, 1)), $urandom());
				1: add_poll(1'($urandom_range(0, 1)), clock_ms - $urandom_range(0, 64));
				default: poll_after(1'($urandom_range(0, 1)),
					$urandom_range(0, 2 * int'(mir_debounce) + 2));
			endcase
		end
	endtask

	// Queue roughly n polls, mostly well-formed gestures.
	task automatic random_polls(int n);
		int stop_at;
		stop_at = n_queued + n;
		while (n_queued < stop_at) begin
			if ($urandom_range(0, 4) == 0)
				noise();
			else
				gesture();
		end
	endtask

	// Wait until every queued poll has been accepted and answered.
	task automatic drain();
		while (n_accepted != n_queued || n_checked != n_accepted)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write one register; keep cfg_valid high so back-to-back writes need
	// only one assignment per step. Call right after a rising edge.
	task automatic cfg_write(bcc_pkg::cfg_idx_t idx, bcc_pkg::cfg_val_t val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			bcc_pkg::REG_DEBOUNCE: mir_debounce = val;
			bcc_pkg::REG_DC_WIN:   mir_window   = val;
			bcc_pkg::REG_SETTLE:   mir_settle   = val;
			bcc_pkg::REG_HOLD:     mir_hold     = val;
			default: ;
		endcase
	endtask

	task automatic apply_cfg(bcc_pkg::cfg_val_t d, bcc_pkg::cfg_val_t w,
		bcc_pkg::cfg_val_t s, bcc_pkg::cfg_val_t h);
		cfg_write(bcc_pkg::REG_DEBOUNCE, d);
		cfg_write(bcc_pkg::REG_DC_WIN, w);
		cfg_write(bcc_pkg::REG_SETTLE, s);
		cfg_write(bcc_pkg::REG_HOLD, h);
		cfg_valid <= 1'b0;
	endtask

	// Directed polls against the reset settings (5 / 250 / 300 / 500 ms).
	task automatic directed_polls();
		add_poll(1'b1, 32'd0);
		// First press before any release: window test runs against the
		// reset release stamp, arms a double click, reported after settle.
		add_poll(1'b0, 32'd10);
		add_poll(1'b0, 32'd16);
		add_poll(1'b1, 32'd30);
		add_poll(1'b1, 32'd36);
		add_poll(1'b1, 32'd337);
		// Long press: hold at exactly the hold time, no click after release.
		add_poll(1'b0, 32'd400);
		add_poll(1'b0, 32'd406);
		add_poll(1'b0, 32'd906);
		add_poll(1'b1, 32'd910);
		add_poll(1'b1, 32'd916);
		add_poll(1'b1, 32'd1217);
		// Plain single click.
		add_poll(1'b0, 32'd2000);
		add_poll(1'b0, 32'd2006);
		add_poll(1'b1, 32'd2100);
		add_poll(1'b1, 32'd2106);
		add_poll(1'b1, 32'd2407);
		// Stamp wrap during a press, then a hold across the wrap.
		add_poll(1'b0, 32'hFFFF_FFF0);
		add_poll(1'b0, 32'hFFFF_FFFA);
		add_poll(1'b0, 32'h0000_01F0);
		// Stamp running backwards, then the extremes of the stamp.
		add_poll(1'b1, 32'h0000_0100);
		add_poll(1'b1, 32'h0000_0080);
		add_poll(1'b1, 32'hFFFF_FFFF);
		add_poll(1'b0, 32'h0000_0000);
	endtask

	// ---------------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------------
	initial begin
		// Hold reset, then release it for good.
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: directed corners first, then random gestures.
		directed_polls();
		drain();
		random_polls(250);
		drain();

		// All registers at zero: a raw change is accepted at the first later poll with a different stamp.
		apply_cfg('0, '0, '0, '0);
		random_polls(200);
		drain();

		// All registers at their maximum.
		apply_cfg('1, '1, '1, '1);
		random_polls(200);
		drain();

		// Random moderate settings; the first round also hits an unused index.
		for (int k = 0; k < 4; k++) begin
			if (k == 0)
				cfg_write(REG_NONE, bcc_pkg::cfg_val_t'($urandom()));
			apply_cfg(bcc_pkg::cfg_val_t'($urandom_range(0, 40)),
				bcc_pkg::cfg_val_t'($urandom_range(0, 600)),
				bcc_pkg::cfg_val_t'($urandom_range(0, 600)),
				bcc_pkg::cfg_val_t'($urandom_range(0, 900)));
			random_polls(230);
			drain();
		end

		// Final phase at full rate: drop all idling on both sides.
		idle_en <= 1'b0;
		apply_cfg(bcc_pkg::cfg_val_t'($urandom_range(0, 20)),
			bcc_pkg::cfg_val_t'($urandom_range(50, 400)),
			bcc_pkg::cfg_val_t'($urandom_range(50, 400)),
			bcc_pkg::cfg_val_t'($urandom_range(100, 700)));
		random_polls(300);
		drain();

		if (pending_flags.size() != 0) begin
			$error("%0d predicted results never arrived", pending_flags.size());
			n_errors++;
		end
		repeat (10) @(posedge clk);

		if (n_errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
